// File: rtl/ctts_pkg.sv
// Shared operation codes, result codes and fixed field widths of the task table scheduler.
`default_nettype none

package ctts_pkg;

    localparam int ID_W        = 8;
    localparam int IN_TIME_W   = 24;
    localparam int SLOT_W      = 4;
    localparam int OCC_W       = 5;
    localparam int TICK_W      = 16;
    localparam int MAX_RESULTS = 16;
    localparam int BUF_W       = $clog2(MAX_RESULTS);
    localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        K_ADD      = 2'd0,
        K_DELETE   = 2'd1,
        K_TICK     = 2'd2,
        K_DISPATCH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_FULL       = 3'd1,
        ST_DONE       = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_NONE       = 3'd4
    } status_t;

endpackage

`default_nettype wire

// File: rtl/ctts_slot_ram.sv
// Slot table memory: one write port, one read port with registered read data.
`default_nettype none

module ctts_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 56
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/cooperative_task_table_scheduler_core.sv
// Top level of the cooperative task table scheduler: sequencer, slot flags and result port.
`default_nettype none

// Usage
// A command transaction is taken at a rising edge where start is high and busy is low.
// kind selects add, delete, tick or dispatch; the other fields are read at that edge.
// Each result is shown for one cycle with done high; last marks the final result of
// a command. The receiver cannot stall, so results are never held back.
// Command behaviour:
//   delete: answered from idle, busy never rises.
//   add: answered from idle when the table is full, otherwise after a free-slot scan.
//   tick: a walk over all slots; dispatch: a walk over all slots, then one none result
//   when nothing is ready, otherwise n results (n at most 16).
// Tick walks the slot memory one read-modify-write per cycle through its single read
// and single write port; dispatch reads one slot per cycle and writes nothing back.
// A new command may be taken in the cycle that shows the final result.
// Reset frees every slot at once through the slot valid flags and zeroes the tick
// counter; there is no clearing pass over the memory.

module cooperative_task_table_scheduler_core #(
    parameter int SLOT_COUNT = 16,
    parameter int TIME_BITS  = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  task_id,
    input  wire logic [23:0] task_delay,
    input  wire logic [23:0] task_period,
    input  wire logic [3:0]  slot_index,
    output logic             done,
    output logic [2:0]       status,
    output logic [3:0]       out_slot,
    output logic [7:0]       out_task_id,
    output logic             last,
    output logic [4:0]       occupied_count,
    output logic [15:0]      tick_value
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int DATA_W = ctts_pkg::ID_W + 2 * TIME_BITS;
    localparam int NUM_W  = ctts_pkg::NUM_W;
    localparam int BUF_W  = ctts_pkg::BUF_W;

    typedef enum logic [2:0] {
        IDLE,
        ADD,
        WALK,
        WRAP,
        EMIT
    } state_t;

    function automatic logic [3:0] to_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W+3:0] w;
        w = {4'b0000, i};
        return w[3:0];
    endfunction

    function automatic logic [4:0] to_occ(input logic [CW-1:0] c);
        logic [CW+4:0] w;
        w = {5'b00000, c};
        return w[4:0];
    endfunction

    state_t                   state_reg, state_next;
    ctts_pkg::kind_t          kind_reg, kind_next;
    logic [7:0]               id_reg, id_next;
    logic [TIME_BITS-1:0]     delay_reg, delay_next;
    logic [TIME_BITS-1:0]     period_reg, period_next;
    logic [SLOT_COUNT-1:0]    valid_reg, valid_next;
    logic [SLOT_COUNT-1:0]    ready_reg, ready_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [15:0]              tick_reg, tick_next;
    logic [CW-1:0]            rd_idx_reg, rd_idx_next;
    logic                     p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]         p_idx_reg, p_idx_next;
    logic [NUM_W-1:0]         n_reg, n_next;
    logic [BUF_W-1:0]         e_idx_reg, e_idx_next;

    logic                     done_reg, done_next;
    ctts_pkg::status_t        status_reg, status_next;
    logic [3:0]               slot_reg, slot_next;
    logic [7:0]               out_id_reg, out_id_next;
    logic                     last_reg, last_next;
    logic [4:0]               occ_reg, occ_next;
    logic [15:0]              tickv_reg, tickv_next;

    logic [3:0]               buf_slot [ctts_pkg::MAX_RESULTS];
    logic [7:0]               buf_id   [ctts_pkg::MAX_RESULTS];
    logic                     buf_we;
    logic [BUF_W-1:0]         buf_waddr;
    logic [3:0]               buf_wslot;
    logic [7:0]               buf_wid;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     rd_issue;

    logic [7:0]               rd_id;
    logic [TIME_BITS-1:0]     rd_delay;
    logic [TIME_BITS-1:0]     rd_period;

    logic [TIME_BITS+23:0]    in_delay_wide;
    logic [TIME_BITS+23:0]    in_period_wide;
    logic [IDX_W+3:0]         del_wide;
    logic [IDX_W-1:0]         del_idx;
    logic                     del_in_range;
    logic [IDX_W-1:0]         scan_idx;

    assign in_delay_wide  = {{TIME_BITS{1'b0}}, task_delay};
    assign in_period_wide = {{TIME_BITS{1'b0}}, task_period};
    assign del_wide       = {{IDX_W{1'b0}}, slot_index};
    assign del_idx        = del_wide[IDX_W-1:0];
    assign del_in_range   = ({3'b000, slot_index} < 7'(SLOT_COUNT));
    assign scan_idx       = rd_idx_reg[IDX_W-1:0];

    assign rd_id     = ram_rdata[DATA_W-1 -: 8];
    assign rd_delay  = ram_rdata[2*TIME_BITS-1:TIME_BITS];
    assign rd_period = ram_rdata[TIME_BITS-1:0];

    ctts_slot_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        delay_next  = delay_reg;
        period_next = period_reg;
        valid_next  = valid_reg;
        ready_next  = ready_reg;
        count_next  = count_reg;
        tick_next   = tick_reg;
        rd_idx_next = rd_idx_reg;
        p_vld_next  = 1'b0;
        p_idx_next  = p_idx_reg;
        n_next      = n_reg;
        e_idx_next  = e_idx_reg;

        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        out_id_next = out_id_reg;
        last_next   = last_reg;
        occ_next    = occ_reg;
        tickv_next  = tickv_reg;

        buf_we      = 1'b0;
        buf_waddr   = n_reg[BUF_W-1:0];
        buf_wslot   = to_slot(p_idx_reg);
        buf_wid     = rd_id;

        ram_we      = 1'b0;
        ram_waddr   = p_idx_reg;
        ram_wdata   = {rd_id, rd_delay, rd_period};
        ram_raddr   = scan_idx;
        rd_issue    = 1'b0;

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    kind_next = ctts_pkg::kind_t'(kind);
                    unique case (ctts_pkg::kind_t'(kind))
                        ctts_pkg::K_ADD:
                        begin
                            id_next     = task_id;
                            delay_next  = in_delay_wide[TIME_BITS-1:0];
                            period_next = in_period_wide[TIME_BITS-1:0];
                            rd_idx_next = '0;
                            if (count_reg == CW'(SLOT_COUNT))
                            begin
                                done_next   = 1'b1;
                                status_next = ctts_pkg::ST_FULL;
                                slot_next   = 4'd0;
                                out_id_next = 8'd0;
                                last_next   = 1'b1;
                                occ_next    = to_occ(count_reg);
                                tickv_next  = tick_reg;
                            end
                            else
                            begin
                                state_next = ADD;
                            end
                        end
                        ctts_pkg::K_DELETE:
                        begin
                            if (del_in_range && valid_reg[del_idx])
                            begin
                                valid_next[del_idx] = 1'b0;
                                ready_next[del_idx] = 1'b0;
                                count_next          = count_reg - CW'(1);
                            end
                            done_next   = 1'b1;
                            status_next = ctts_pkg::ST_DONE;
                            slot_next   = slot_index;
                            out_id_next = 8'd0;
                            last_next   = 1'b1;
                            occ_next    = to_occ(count_next);
                            tickv_next  = tick_reg;
                        end
                        ctts_pkg::K_TICK:
                        begin
                            tick_next   = tick_reg + 16'd1;
                            rd_idx_next = '0;
                            state_next  = WALK;
                        end
                        ctts_pkg::K_DISPATCH:
                        begin
                            n_next      = '0;
                            rd_idx_next = '0;
                            state_next  = WALK;
                        end
                    endcase
                end
            end

            ADD:
            begin
                // A free slot always exists here because a full table is answered at once.
                if (!valid_reg[scan_idx])
                begin
                    valid_next[scan_idx] = 1'b1;
                    ready_next[scan_idx] = 1'b0;
                    count_next           = count_reg + CW'(1);
                    ram_we               = 1'b1;
                    ram_waddr            = scan_idx;
                    ram_wdata            = {id_reg, delay_reg, period_reg};
                    done_next            = 1'b1;
                    status_next          = ctts_pkg::ST_ADDED;
                    slot_next            = to_slot(scan_idx);
                    out_id_next          = id_reg;
                    last_next            = 1'b1;
                    occ_next             = to_occ(count_next);
                    tickv_next           = tick_reg;
                    state_next           = IDLE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
            end

            WALK:
            begin
                // Reads run one slot ahead of the write-back, so they never meet on one entry.
                if (rd_idx_reg < CW'(SLOT_COUNT))
                begin
                    rd_issue    = 1'b1;
                    p_vld_next  = 1'b1;
                    p_idx_next  = scan_idx;
                    rd_idx_next = rd_idx_reg + CW'(1);
                end

                if (p_vld_reg && valid_reg[p_idx_reg])
                begin
                    if (kind_reg == ctts_pkg::K_TICK)
                    begin
                        if (rd_delay == '0)
                        begin
                            ready_next[p_idx_reg] = 1'b1;
                            if (rd_period != '0)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {rd_id, rd_period, rd_period};
                            end
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {rd_id, rd_delay - TIME_BITS'(1), rd_period};
                        end
                    end
                    else if (ready_reg[p_idx_reg] && (n_reg < NUM_W'(ctts_pkg::MAX_RESULTS)))
                    begin
                        buf_we                = 1'b1;
                        n_next                = n_reg + NUM_W'(1);
                        ready_next[p_idx_reg] = 1'b0;
                        if (rd_period == '0)
                        begin
                            valid_next[p_idx_reg] = 1'b0;
                            count_next            = count_reg - CW'(1);
                        end
                    end
                end

                if (p_vld_reg && (p_idx_reg == IDX_W'(SLOT_COUNT - 1)))
                begin
                    state_next = WRAP;
                end
            end

            WRAP:
            begin
                e_idx_next = '0;
                if (kind_reg == ctts_pkg::K_TICK)
                begin
                    done_next   = 1'b1;
                    status_next = ctts_pkg::ST_DONE;
                    slot_next   = 4'd0;
                    out_id_next = 8'd0;
                    last_next   = 1'b1;
                    occ_next    = to_occ(count_reg);
                    tickv_next  = tick_reg;
                    state_next  = IDLE;
                end
                else if (n_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ctts_pkg::ST_NONE;
                    slot_next   = 4'd0;
                    out_id_next = 8'd0;
                    last_next   = 1'b1;
                    occ_next    = to_occ(count_reg);
                    tickv_next  = tick_reg;
                    state_next  = IDLE;
                end
                else
                begin
                    state_next = EMIT;
                end
            end

            EMIT:
            begin
                done_next   = 1'b1;
                status_next = ctts_pkg::ST_DISPATCHED;
                slot_next   = buf_slot[e_idx_reg];
                out_id_next = buf_id[e_idx_reg];
                occ_next    = to_occ(count_reg);
                tickv_next  = tick_reg;
                last_next   = ((NUM_W'(e_idx_reg) + NUM_W'(1)) == n_reg);
                if (last_next)
                begin
                    state_next = IDLE;
                end
                else
                begin
                    e_idx_next = e_idx_reg + BUF_W'(1);
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            kind_reg   <= ctts_pkg::K_ADD;
            id_reg     <= '0;
            delay_reg  <= '0;
            period_reg <= '0;
            valid_reg  <= '0;
            ready_reg  <= '0;
            count_reg  <= '0;
            tick_reg   <= '0;
            rd_idx_reg <= '0;
            p_vld_reg  <= 1'b0;
            p_idx_reg  <= '0;
            n_reg      <= '0;
            e_idx_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ctts_pkg::ST_ADDED;
            slot_reg   <= '0;
            out_id_reg <= '0;
            last_reg   <= 1'b0;
            occ_reg    <= '0;
            tickv_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            id_reg     <= id_next;
            delay_reg  <= delay_next;
            period_reg <= period_next;
            valid_reg  <= valid_next;
            ready_reg  <= ready_next;
            count_reg  <= count_next;
            tick_reg   <= tick_next;
            rd_idx_reg <= rd_idx_next;
            p_vld_reg  <= p_vld_next;
            p_idx_reg  <= p_idx_next;
            n_reg      <= n_next;
            e_idx_reg  <= e_idx_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            slot_reg   <= slot_next;
            out_id_reg <= out_id_next;
            last_reg   <= last_next;
            occ_reg    <= occ_next;
            tickv_reg  <= tickv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_slot[buf_waddr] <= buf_wslot;
            buf_id[buf_waddr]   <= buf_wid;
        end
    end

    assign busy           = (state_reg != IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign out_slot       = slot_reg;
    assign out_task_id    = out_id_reg;
    assign last           = last_reg;
    assign occupied_count = occ_reg;
    assign tick_value     = tickv_reg;

`ifndef SYNTHESIS
    a_single_result_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ctts_pkg::ST_DISPATCHED)) |-> last)
        else $error("single-result command did not mark last");

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("occupancy count disagrees with slot valid flags");

    a_delete_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == ctts_pkg::K_DELETE)) |=> (done && last))
        else $error("delete transaction did not answer in the next cycle");

    a_no_same_entry_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && rd_issue) |-> (ram_waddr != ram_raddr))
        else $error("slot memory read and write hit the same entry");
`endif

endmodule

`default_nettype wire
